@@ hdl/serial_interface_register_block_defines.svh @@
// Assertion macros used by the checker file of the serial interface register block.
`ifndef SERIAL_INTERFACE_REGISTER_BLOCK_DEFINES_SVH
`define SERIAL_INTERFACE_REGISTER_BLOCK_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define SIRB_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define SIRB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/sirb_pkg.sv @@
package sirb_pkg;

  typedef enum logic [2:0] {
    CMD_READ       = 3'd0,
    CMD_WRITE      = 3'd1,
    CMD_POLL       = 3'd2,
    CMD_XFER_DONE  = 3'd3,
    CMD_DEV_CHANGE = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    REG_OUT   = 2'd0,
    REG_IN_HI = 2'd1,
    REG_IN_LO = 2'd2
  } chreg_t;

  typedef struct packed {
    logic [1:0] ch;
    chreg_t     sel;
  } chan_dec_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  address;
    logic [31:0] write_data;
    logic [1:0]  channel;
    logic        has_new_data;
    logic [31:0] data_high;
    logic [31:0] data_low;
  } item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq;
    logic        send_pulse;
    logic        transfer_start;
    logic        transfer_abort;
    logic [1:0]  transfer_channel;
    logic [7:0]  in_length;
    logic [7:0]  out_length;
  } result_t;

  localparam logic [7:0] ADDR_POLL    = 8'h30;
  localparam logic [7:0] ADDR_COM_CSR = 8'h34;
  localparam logic [7:0] ADDR_STATUS  = 8'h38;
  localparam logic [7:0] ADDR_CLOCK   = 8'h3C;

  localparam int CSR_TSTART     = 0;
  localparam int CSR_RDSTINTMSK = 27;
  localparam int CSR_RDSTINT    = 28;
  localparam int CSR_COMERR     = 29;
  localparam int CSR_TCINTMSK   = 30;
  localparam int CSR_TCINT      = 31;
  localparam int STATUS_WR      = 31;

  localparam logic [31:0] CSR_COPY_MASK   = 32'h487F_7F06;
  localparam logic [31:0] RDST_ALL        = 32'h2020_2020;
  localparam logic [31:0] STATUS_ERR_MASK = 32'h0F0F_0F0F;
  localparam logic [31:0] STATUS_WR_CLR   = 32'h9010_1010;
  localparam logic [25:0] POLL_RESET      = 26'h007_0000;

  function automatic logic [7:0] len_of(input logic [6:0] f);
    return (f == 7'd0) ? 8'd128 : ({1'b0, f} + 8'd1);
  endfunction

  function automatic logic [31:0] newdata_flag(input logic [1:0] ch);
    return 32'h1 << {~ch, 3'd5};
  endfunction

  function automatic logic [31:0] norep_bit(input logic [1:0] ch);
    return 32'h1 << {~ch, 3'd3};
  endfunction

  function automatic chan_dec_t chan_decode(input logic [3:0] wi);
    chan_dec_t d;
    case (wi)
      4'd0:    d = '{ch: 2'd0, sel: REG_OUT};
      4'd1:    d = '{ch: 2'd0, sel: REG_IN_HI};
      4'd2:    d = '{ch: 2'd0, sel: REG_IN_LO};
      4'd3:    d = '{ch: 2'd1, sel: REG_OUT};
      4'd4:    d = '{ch: 2'd1, sel: REG_IN_HI};
      4'd5:    d = '{ch: 2'd1, sel: REG_IN_LO};
      4'd6:    d = '{ch: 2'd2, sel: REG_OUT};
      4'd7:    d = '{ch: 2'd2, sel: REG_IN_HI};
      4'd8:    d = '{ch: 2'd2, sel: REG_IN_LO};
      4'd9:    d = '{ch: 2'd3, sel: REG_OUT};
      4'd10:   d = '{ch: 2'd3, sel: REG_IN_HI};
      4'd11:   d = '{ch: 2'd3, sel: REG_IN_LO};
      default: d = '{ch: 2'd0, sel: REG_OUT};
    endcase
    return d;
  endfunction

endpackage

@@ hdl/serial_interface_register_block.sv @@
// Register block of a four-channel serial controller. Each item is a bus read or write,
// a poll-data report, a transfer-done event or a device-change event, and yields exactly one
// result item carrying read data, the interrupt level and the transfer/send strobes. One item
// is taken every clock cycle unless in_stall is high; an item is held in the input register
// and its result in the result register, which drives the out_ ports. Every register update
// of one item is done in a single pass so the next item already sees it. Stall on the result
// side holds both stages and backs up to in_stall in the same cycle.
module serial_interface_register_block #(
  parameter int CHANNELS     = 4,
  parameter int BUFFER_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [7:0]  in_address,
  input  logic [31:0] in_write_data,
  input  logic [1:0]  in_channel,
  input  logic        in_has_new_data,
  input  logic [31:0] in_data_high,
  input  logic [31:0] in_data_low,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_read_data,
  output logic        out_irq,
  output logic        out_send_pulse,
  output logic        out_transfer_start,
  output logic        out_transfer_abort,
  output logic [1:0]  out_transfer_channel,
  output logic [7:0]  out_in_length,
  output logic [7:0]  out_out_length
);
  import sirb_pkg::*;

  item_t   item_in;
  item_t   item_r;
  result_t res_c;
  result_t res_r;
  logic    v1_r, v2_r;
  logic    load2;
  logic    fire;

  assign item_in = '{command: in_command, address: in_address, write_data: in_write_data,
                     channel: in_channel, has_new_data: in_has_new_data,
                     data_high: in_data_high, data_low: in_data_low};

  assign load2    = !v2_r || !out_stall;
  assign fire     = v1_r && load2;
  assign in_stall = v1_r && !load2;

  sirb_core #(
    .CHANNELS    (CHANNELS),
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire_i(fire),
    .item_i(item_r),
    .res_o (res_c)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        v1_r <= in_valid;
      end
      if (load2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= item_in;
    end
    if (fire) begin
      res_r <= res_c;
    end
  end

  assign out_valid            = v2_r;
  assign out_read_data        = res_r.read_data;
  assign out_irq              = res_r.irq;
  assign out_send_pulse       = res_r.send_pulse;
  assign out_transfer_start   = res_r.transfer_start;
  assign out_transfer_abort   = res_r.transfer_abort;
  assign out_transfer_channel = res_r.transfer_channel;
  assign out_in_length        = res_r.in_length;
  assign out_out_length       = res_r.out_length;

endmodule

@@ hdl/sirb_core.sv @@
module sirb_core #(
  parameter int CHANNELS     = 4,
  parameter int BUFFER_BYTES = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire_i,
  input  sirb_pkg::item_t   item_i,
  output sirb_pkg::result_t res_o
);
  import sirb_pkg::*;

  localparam int BUF_WORDS = BUFFER_BYTES / 4;
  localparam int BUF_AW    = (BUF_WORDS > 1) ? $clog2(BUF_WORDS) : 1;
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [23:0] out_word_r [CHANNELS];
  logic [31:0] in_hi_r    [CHANNELS];
  logic [31:0] in_lo_r    [CHANNELS];
  logic [31:0] buf_r      [BUF_WORDS];
  logic [25:0] poll_r, poll_nxt;
  logic [31:0] csr_r, csr_nxt;
  logic [31:0] chst_r, chst_nxt;
  logic [31:0] clock_r, clock_nxt;

  logic [7:0]        addr;
  logic              is_buf;
  logic              is_chan;
  logic              buf_ok;
  logic [BUF_AW-1:0] bidx;
  chan_dec_t         dec;
  logic              dch_ok;
  logic              ich_ok;
  logic [CH_W-1:0]   dch_i;

  logic            out_we, hi_we, lo_we, buf_we;
  logic [23:0]     out_d;
  logic [31:0]     hi_d, lo_d;
  logic [1:0]      wr_ch;
  logic [CH_W-1:0] wr_i;
  result_t         res;
  logic [31:0]     c;

  assign addr    = {item_i.address[7:2], 2'b00};
  assign is_buf  = addr[7];
  assign is_chan = !addr[7] && !addr[6] && (addr[5:4] != 2'b11);
  assign bidx    = addr[BUF_AW+1:2];
  assign buf_ok  = is_buf && ({1'b0, addr[6:2]} < 6'(BUF_WORDS));
  assign dec     = chan_decode(addr[5:2]);
  assign dch_ok  = {1'b0, dec.ch} < 3'(CHANNELS);
  assign ich_ok  = {1'b0, item_i.channel} < 3'(CHANNELS);
  assign dch_i   = dec.ch[CH_W-1:0];
  assign wr_i    = wr_ch[CH_W-1:0];

  always_comb begin
    csr_nxt   = csr_r;
    chst_nxt  = chst_r;
    poll_nxt  = poll_r;
    clock_nxt = clock_r;
    out_we    = 1'b0;
    hi_we     = 1'b0;
    lo_we     = 1'b0;
    buf_we    = 1'b0;
    out_d     = '0;
    hi_d      = '0;
    lo_d      = '0;
    wr_ch     = item_i.channel;
    res       = '0;
    c         = csr_r;
    case (cmd_t'(item_i.command))
      CMD_READ: begin
        if (is_buf) begin
          if (buf_ok) begin
            res.read_data = buf_r[bidx];
          end
        end else if (is_chan) begin
          if (dch_ok) begin
            case (dec.sel)
              REG_OUT: begin
                res.read_data = {8'h00, out_word_r[dch_i]};
              end
              REG_IN_HI: begin
                chst_nxt = chst_r & ~newdata_flag(dec.ch);
                csr_nxt[CSR_RDSTINT] = |(chst_nxt & RDST_ALL);
                res.read_data = in_hi_r[dch_i];
              end
              REG_IN_LO: begin
                chst_nxt = chst_r & ~newdata_flag(dec.ch);
                csr_nxt[CSR_RDSTINT] = |(chst_nxt & RDST_ALL);
                res.read_data = in_lo_r[dch_i];
              end
              default: ;
            endcase
          end
        end else begin
          case (addr)
            ADDR_POLL:    res.read_data = {6'h00, poll_r};
            ADDR_COM_CSR: res.read_data = csr_r;
            ADDR_STATUS:  res.read_data = chst_r;
            ADDR_CLOCK:   res.read_data = clock_r;
            default:      res.read_data = '0;
          endcase
        end
      end
      CMD_WRITE: begin
        if (is_buf) begin
          buf_we = buf_ok;
        end else if (is_chan) begin
          wr_ch = dec.ch;
          if (dch_ok) begin
            case (dec.sel)
              REG_OUT: begin
                out_we = 1'b1;
                out_d  = item_i.write_data[23:0];
              end
              REG_IN_HI: begin
                hi_we = 1'b1;
                hi_d  = item_i.write_data;
              end
              REG_IN_LO: begin
                lo_we = 1'b1;
                lo_d  = item_i.write_data;
              end
              default: ;
            endcase
          end
        end else begin
          case (addr)
            ADDR_POLL: begin
              poll_nxt = item_i.write_data[25:0];
            end
            ADDR_COM_CSR: begin
              c = (csr_r & ~CSR_COPY_MASK) | (item_i.write_data & CSR_COPY_MASK);
              c[CSR_COMERR] = 1'b0;
              if (item_i.write_data[CSR_RDSTINT]) begin
                c[CSR_RDSTINT] = 1'b0;
              end
              if (item_i.write_data[CSR_TCINT]) begin
                c[CSR_TCINT] = 1'b0;
              end
              if (item_i.write_data[CSR_TSTART]) begin
                c[CSR_TSTART]        = 1'b1;
                res.transfer_start   = 1'b1;
                res.transfer_channel = c[2:1];
                res.in_length        = len_of(c[14:8]);
                res.out_length       = len_of(c[22:16]);
              end else if (c[CSR_TSTART]) begin
                res.transfer_abort = 1'b1;
                c[CSR_TSTART]      = 1'b0;
              end
              if (!c[CSR_TSTART]) begin
                c[CSR_RDSTINT] = |(chst_r & RDST_ALL);
              end
              csr_nxt = c;
            end
            ADDR_STATUS: begin
              chst_nxt = chst_r & ~(item_i.write_data & STATUS_ERR_MASK);
              if (item_i.write_data[STATUS_WR]) begin
                res.send_pulse = 1'b1;
                chst_nxt       = chst_nxt & ~STATUS_WR_CLR;
              end
            end
            ADDR_CLOCK: begin
              clock_nxt = item_i.write_data;
            end
            default: ;
          endcase
        end
      end
      CMD_POLL: begin
        if (ich_ok) begin
          hi_we = 1'b1;
          hi_d  = item_i.data_high;
          lo_we = 1'b1;
          lo_d  = item_i.data_low;
          if (item_i.has_new_data) begin
            chst_nxt = chst_r | newdata_flag(item_i.channel);
          end else begin
            chst_nxt = chst_r & ~newdata_flag(item_i.channel);
          end
          csr_nxt[CSR_RDSTINT] = |(chst_nxt & RDST_ALL);
        end
      end
      CMD_XFER_DONE: begin
        if (csr_r[CSR_TSTART]) begin
          csr_nxt[CSR_TSTART]  = 1'b0;
          csr_nxt[CSR_TCINT]   = 1'b1;
          csr_nxt[CSR_RDSTINT] = |(chst_r & RDST_ALL);
        end
      end
      CMD_DEV_CHANGE: begin
        if (ich_ok) begin
          out_we              = 1'b1;
          hi_we               = 1'b1;
          lo_we               = 1'b1;
          chst_nxt            = chst_r | norep_bit(item_i.channel);
          csr_nxt[CSR_COMERR] = 1'b1;
        end
      end
      default: ;
    endcase
    res.irq = (csr_nxt[CSR_RDSTINT] & csr_nxt[CSR_RDSTINTMSK]) |
              (csr_nxt[CSR_TCINT] & csr_nxt[CSR_TCINTMSK]);
  end

  assign res_o = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_r  <= POLL_RESET;
      csr_r   <= '0;
      chst_r  <= '0;
      clock_r <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        out_word_r[i] <= '0;
        in_hi_r[i]    <= '0;
        in_lo_r[i]    <= '0;
      end
      for (int j = 0; j < BUF_WORDS; j++) begin
        buf_r[j] <= '0;
      end
    end else if (fire_i) begin
      poll_r  <= poll_nxt;
      csr_r   <= csr_nxt;
      chst_r  <= chst_nxt;
      clock_r <= clock_nxt;
      if (out_we) begin
        out_word_r[wr_i] <= out_d;
      end
      if (hi_we) begin
        in_hi_r[wr_i] <= hi_d;
      end
      if (lo_we) begin
        in_lo_r[wr_i] <= lo_d;
      end
      if (buf_we) begin
        buf_r[bidx] <= item_i.write_data;
      end
    end
  end

endmodule

@@ hdl/sirb_checker.sv @@
`include "serial_interface_register_block_defines.svh"

module sirb_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_read_data,
  input logic        out_send_pulse,
  input logic        out_transfer_start,
  input logic        out_transfer_abort,
  input logic [1:0]  out_transfer_channel,
  input logic [7:0]  out_in_length,
  input logic [7:0]  out_out_length
);

  `SIRB_ASSERT_SAME(a_start_abort_excl, out_valid, !(out_transfer_start && out_transfer_abort), "transfer start and abort in one item")
  `SIRB_ASSERT_SAME(a_idle_xfer_zero, out_valid && !out_transfer_start, out_transfer_channel == 2'd0 && out_in_length == 8'd0 && out_out_length == 8'd0, "transfer fields set without start")
  `SIRB_ASSERT_SAME(a_len_range, out_valid && out_transfer_start, out_in_length != 8'd0 && out_out_length != 8'd0 && (!out_in_length[7] || out_in_length[6:0] == 7'd0) && (!out_out_length[7] || out_out_length[6:0] == 7'd0), "transfer length outside 1..128")
  `SIRB_ASSERT_SAME(a_strobe_no_data, out_valid && (out_send_pulse || out_transfer_start || out_transfer_abort), out_read_data == 32'd0, "write strobe with read data")
  `SIRB_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(out_read_data), "stalled item changed")

endmodule

bind serial_interface_register_block sirb_checker u_sirb_checker (.*);
